>>> hdl/assert_macros.svh
// Assertion helpers for the RTL, included by longest_distinct_run_length.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define LDRL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ldrl assertion failed");
// Check that a condition never holds outside reset.
`define LDRL_NEVER(lbl, clk, rst_n, expr) `LDRL_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define LDRL_ASSERT(lbl, clk, rst_n, prop)
`define LDRL_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> hdl/ldrl_pkg.sv
package ldrl_pkg;

  // Widths of the stream fields
  localparam int SYM_IN_W = 8;
  localparam int LEN_W    = 16;

  // Saturation value for the reported lengths
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  // One result request, first field in the highest bits
  typedef struct packed {
    logic             overflow;
    logic             is_final;
    logic [LEN_W-1:0] best_length;
    logic [LEN_W-1:0] window_length;
  } result_t;

endpackage

>>> hdl/ldrl_ram.sv
module ldrl_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/longest_distinct_run_length.sv
// Longest run of distinct bytes in a streamed string.
// Input stream: one byte per request in in_tdata, in_tlast on the final byte
// of the string. Output stream: one result per input byte; out_tdata carries
// the length of the repeat-free window ending at that byte and the best
// length so far, out_tlast copies the final-byte flag (best is then the
// answer), out_tuser flags a string longer than MAX_LEN (lengths saturate).
// An accepted byte passes the registered read of the last-position table and
// then the update stage, which feeds the output register. Throughput is one
// byte per cycle while the receiver keeps up; a write to the same table entry
// by the byte just before is forwarded around the memory.
// When the receiver stalls, the output register and the update stage fill,
// then in_tready drops; no result is lost or repeated.
// Reset clears the seen marks, position counter, window start, best length
// and overflow flag; the position table itself is never cleared, since the
// per-symbol seen marks guard every read. The same per-string state clears
// after the final byte, so the next string can follow in the next cycle.
`include "assert_macros.svh"

module longest_distinct_run_length
  import ldrl_pkg::*;
#(
  parameter longint unsigned MAX_LEN  = 65535,
  parameter int              ALPHABET = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] window_length, [31:16] best_length
  output logic        out_tlast,  // is_final
  output logic        out_tuser   // overflow
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int SYM_W = $clog2(ALPHABET);
  localparam int EXT_W = (POS_W > LEN_W) ? POS_W : LEN_W;

  // Pipeline control
  logic             in_acc;
  logic             fire;
  logic             s1_valid_r;
  logic [SYM_W-1:0] s1_sym_r;
  logic             s1_fin_r;
  logic             fwd_hit_r;
  logic [POS_W-1:0] fwd_pos_r;
  logic [SYM_W-1:0] in_sym;

  // Per-string state
  logic [ALPHABET-1:0] seen_r;
  logic [POS_W-1:0]    start_r;
  logic [POS_W-1:0]    start_nxt;
  logic [POS_W-1:0]    idx_r;
  logic [POS_W-1:0]    idx_nxt;
  logic [POS_W-1:0]    best_r;
  logic [POS_W-1:0]    best_nxt;
  logic                ovf_r;

  // Update stage
  logic [POS_W-1:0] ram_rdata;
  logic [POS_W-1:0] last_pos;
  logic             ovf_now;
  logic             in_window;
  logic [POS_W-1:0] win;
  logic             ram_we;

  // Output register
  logic    out_valid_r;
  result_t out_r;
  result_t res_nxt;

  function automatic logic [LEN_W-1:0] sat16(input logic [POS_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return (ext > EXT_W'(LEN_SAT)) ? LEN_SAT : ext[LEN_W-1:0];
  endfunction

  // Fold out-of-alphabet symbols onto the top entry
  assign in_sym = ({1'b0, in_tdata} >= 9'(ALPHABET)) ? SYM_W'(ALPHABET - 1)
                                                      : in_tdata[SYM_W-1:0];

  // Handshake: stage 1 moves when the output slot is free or draining
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  ldrl_ram #(
    .WIDTH (POS_W),
    .DEPTH (ALPHABET)
  ) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_sym_r),
    .wdata (idx_r),
    .re    (in_acc),
    .raddr (in_sym),
    .rdata (ram_rdata)
  );

  // Advance stage 1 and capture forwarding from the byte being written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sym_r  <= in_sym;
      s1_fin_r  <= in_tlast;
      fwd_hit_r <= ram_we && (s1_sym_r == in_sym);
      fwd_pos_r <= idx_r;
    end
  end

  // Compute the window update for the byte in stage 1
  always_comb begin
    last_pos  = fwd_hit_r ? fwd_pos_r : ram_rdata;
    ovf_now   = (idx_r >= POS_W'(MAX_LEN));
    in_window = seen_r[s1_sym_r] && (last_pos >= start_r);
    start_nxt = in_window ? last_pos + POS_W'(1) : start_r;
    win       = idx_r - start_nxt + POS_W'(1);
    best_nxt  = (win > best_r) ? win : best_r;
    idx_nxt   = idx_r + POS_W'(1);
    ram_we    = fire && !ovf_now;

    res_nxt.is_final = s1_fin_r;
    if (ovf_now) begin
      res_nxt.window_length = '0;
      res_nxt.best_length   = sat16(best_r);
      res_nxt.overflow      = 1'b1;
    end else begin
      res_nxt.window_length = sat16(win);
      res_nxt.best_length   = sat16(best_nxt);
      res_nxt.overflow      = ovf_r;
    end
  end

  // Commit per-string state; drop it all after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      start_r <= '0;
      idx_r   <= '0;
      best_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      if (s1_fin_r) begin
        seen_r  <= '0;
        start_r <= '0;
        idx_r   <= '0;
        best_r  <= '0;
        ovf_r   <= 1'b0;
      end else if (ovf_now) begin
        ovf_r <= 1'b1;
      end else begin
        seen_r[s1_sym_r] <= 1'b1;
        start_r          <= start_nxt;
        idx_r            <= idx_nxt;
        best_r           <= best_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.best_length, out_r.window_length};
  assign out_tlast  = out_r.is_final;
  assign out_tuser  = out_r.overflow;

  // Window never starts past the next position, which never passes the limit
  `LDRL_ASSERT(a_start_le_idx, clk, rst_n, start_r <= idx_r)
  `LDRL_ASSERT(a_idx_le_max, clk, rst_n, idx_r <= POS_W'(MAX_LEN))
  // An overflowed byte never touches the position table
  `LDRL_NEVER(a_ovf_no_write, clk, rst_n, fire && ovf_now && ram_we)
  // Overflow results report an empty window
  `LDRL_ASSERT(a_ovf_zero_win, clk, rst_n,
               (fire && ovf_now) |=> out_r.window_length == '0)
  // Best length always covers the current window
  `LDRL_ASSERT(a_best_ge_win, clk, rst_n,
               out_valid_r |-> (out_r.best_length >= out_r.window_length))

endmodule

>>> tb/sv/tb_longest_distinct_run_length.sv
module tb_longest_distinct_run_length
  import ldrl_pkg::*;
();

  localparam longint unsigned RUN_MAX = 65535;
  localparam int SYMBOLS = 256;
  localparam int HALF_PERIOD = 6;
  localparam int LIMIT_CYCLES = 900000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [SYM_IN_W-1:0] symbol;
    logic                fin;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] symbol
  logic        in_tlast = 1'b0; // final_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [15:0] window_length, [31:16] best_length
  logic        out_tlast;       // is_final
  logic        out_tuser;       // overflow

  byte_req_t pending_bytes[$];
  result_t   expected_results[$];
  int        send_idle = 0;
  int        recv_idle = 0;
  logic      hold_req = 1'b0;
  logic      hold_taken;
  int        hold_left;
  int        mismatches = 0;

  // Shadow of the per-string tracking state
  longint unsigned pos_table[SYMBOLS];
  bit              seen_table[SYMBOLS];
  longint unsigned run_start;
  longint unsigned next_pos;
  longint unsigned longest;
  bit              too_long;

  longest_distinct_run_length #(
    .MAX_LEN (RUN_MAX),
    .ALPHABET(SYMBOLS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void clear_string();
    for (int i = 0; i < SYMBOLS; i++) seen_table[i] = 1'b0;
    run_start = 0;
    next_pos  = 0;
    longest   = 0;
    too_long  = 1'b0;
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(longint unsigned v);
    return (v > LEN_SAT) ? LEN_SAT : v[LEN_W-1:0];
  endfunction

  // Advance the sliding window by one byte and form its result
  function automatic result_t track_byte(logic [7:0] symbol, logic fin);
    int unsigned     s;
    longint unsigned win;
    result_t         r;
    s   = symbol;
    win = 0;
    if (s >= SYMBOLS) s = SYMBOLS - 1;
    if (next_pos >= RUN_MAX) begin
      too_long = 1'b1;
    end else begin
      // move the window start past an earlier copy still inside the window
      if (seen_table[s] && pos_table[s] >= run_start) run_start = pos_table[s] + 1;
      pos_table[s]  = next_pos;
      seen_table[s] = 1'b1;
      win = next_pos - run_start + 1;
      if (win > longest) longest = win;
      next_pos = next_pos + 1;
    end
    r.window_length = sat_len(win);
    r.best_length   = sat_len(longest);
    r.is_final      = fin;
    r.overflow      = too_long;
    if (fin) clear_string();
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic add_bytes(logic [7:0] b[]);
    foreach (b[i]) pending_bytes.push_back('{b[i], i == b.size() - 1});
  endtask

  // Queue random strings of several shapes until about n_bytes are queued
  task automatic add_random_strings(int n_bytes);
    int         added;
    int         kind;
    int         len;
    int         span;
    logic [7:0] base;
    logic [7:0] stride;
    logic [7:0] sym;
    added = 0;
    while (added < n_bytes) begin
      kind   = $urandom_range(9);
      base   = 8'($urandom_range(255));
      span   = $urandom_range(1, 12);
      stride = {7'($urandom_range(127)), 1'b1};
      case (kind) inside
        [0:5]:   len = $urandom_range(1, 30);
        [6:7]:   len = $urandom_range(1, 60);
        8:       len = $urandom_range(200, 270);
        default: len = 1;
      endcase
      for (int i = 0; i < len; i++) begin
        case (kind) inside
          [0:5]:   sym = 8'(base + $urandom_range(span - 1));
          8:       sym = 8'(base + stride * i);
          default: sym = 8'($urandom_range(255));
        endcase
        pending_bytes.push_back('{sym, i == len - 1});
      end
      added += len;
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Sender: record the accepted request, then offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(track_byte(in_tdata, in_tlast));
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes[0].symbol;
          in_tlast  <= pending_bytes[0].fin;
          void'(pending_bytes.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: window_length %0d best_length %0d",
               out_tdata[15:0], out_tdata[31:16]);
        mismatches++;
      end else begin
        check_field("window_length", expected_results[0].window_length, out_tdata[15:0]);
        check_field("best_length", expected_results[0].best_length, out_tdata[31:16]);
        check_field("is_final", expected_results[0].is_final, out_tlast);
        check_field("overflow", expected_results[0].overflow, out_tuser);
        void'(expected_results.pop_front());
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < SYMBOLS; i++) pos_table[i] = 0;
    clear_string();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase 1: sender mostly busy, receiver mostly stalled
    send_idle = 18;
    recv_idle = 88;
    add_bytes('{8'h00});                                       // single byte
    add_bytes('{8'hFF, 8'hFF, 8'hFF});                         // same byte repeated
    add_bytes('{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62});
    add_bytes('{8'h61, 8'h62, 8'h62, 8'h61});                  // repeat outside window
    add_bytes('{8'h70, 8'h77, 8'h77, 8'h6B, 8'h65, 8'h77});
    add_random_strings(260);
    wait_drained();

    // Phase 2: sender mostly idle, receiver mostly ready
    send_idle = 88;
    recv_idle = 18;
    add_random_strings(260);
    wait_drained();

    // Phase 3: no idling, with a long receiver hold-off while the sender keeps offering
    send_idle = 0;
    recv_idle = 0;
    add_random_strings(260);
    add_bytes('{8'h00, 8'h01});
    hold_req = 1'b1;
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ldrl_pkg.sv
hdl/ldrl_ram.sv
hdl/longest_distinct_run_length.sv
tb/sv/tb_longest_distinct_run_length.sv
